// ----- rtl/rc4_stream_cipher_top_defines.svh -----
// Assertion macros used by the property checker in rtl/rc4_checker.sv.
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define RC4_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define RC4_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rc4_pkg.sv -----
package rc4_pkg;

   localparam int BYTE_W          = 8;
   localparam int PERM_DEPTH      = 256;
   localparam int MAX_KEY_DEFAULT = 256;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] byte_in;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic              last_out;
   } rsp_type;

endpackage

// ----- rtl/rc4_ram.sv -----
module rc4_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rc4_stream_cipher_top.sv -----
// RC4 stream cipher, one byte per transfer.
// Input channel req_*: each transfer carries either a key byte (op = key) or a
// data byte (op = data). Key bytes are stored; the key byte marked last starts
// the key schedule. Output channel rsp_*: one transfer per data byte, carrying
// the data byte XOR the keystream byte and a copy of its last flag.
// A data byte steps through states D1, D2 and D3, and its result is
// registered once the output register is free; req_stall stays high until
// then, so a new byte is taken only when the last is done. The steps are set
// by the three dependent reads and two writes of the permutation memory.
// A key byte without the last flag is stored and the block stays idle. A last
// key byte starts the schedule: state FILL refills all 256 permutation
// entries with the identity, then states M0 to M3 mix the key into each.
// After reset the block writes the identity into all 256 permutation entries,
// with req_stall high; the key store itself is not cleared.
// When the receiver stalls, the finished result waits in the output register
// and the block holds the next data byte in its last step until it drains.
module rc4_stream_cipher_top #(
   parameter int MAX_KEY = rc4_pkg::MAX_KEY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rc4_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rc4_pkg::rsp_type rsp_data
);

   import rc4_pkg::*;

   localparam int KCW    = $clog2(MAX_KEY + 1);
   localparam int KEY_AW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

   localparam logic [3:0] ST_FILL = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_D1   = 4'd2;
   localparam logic [3:0] ST_D2   = 4'd3;
   localparam logic [3:0] ST_D3   = 4'd4;
   localparam logic [3:0] ST_M0   = 4'd5;
   localparam logic [3:0] ST_M1   = 4'd6;
   localparam logic [3:0] ST_M2   = 4'd7;
   localparam logic [3:0] ST_M3   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [7:0]        k_ff, k_in;
   logic              sched_ff, sched_in;
   logic [KCW-1:0]    key_count_ff, key_count_in;
   logic [KCW-1:0]    klen_ff, klen_in;
   logic [KEY_AW-1:0] kidx_ff, kidx_in;
   logic [7:0]        i_ff, i_in;
   logic [7:0]        j_ff, j_in;
   logic [7:0]        a_ff, a_in;
   logic [7:0]        c_ff, c_in;
   logic [7:0]        t_ff, t_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              perm_we;
   logic [7:0]        perm_wa, perm_wd, perm_ra, perm_rd;
   logic              key_we;
   logic [KEY_AW-1:0] key_wa, key_ra;
   logic [7:0]        key_rd;

   logic              req_xfer;
   logic              rsp_free;
   logic              cnt_sat;
   logic [KCW-1:0]    cnt_next;
   logic [7:0]        i_next, j_next, t_next, ks;

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_wa),
      .wr_data (perm_wd),
      .rd_addr (perm_ra),
      .rd_data (perm_rd)
   );

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (req_data.byte_in),
      .rd_addr (key_ra),
      .rd_data (key_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_sat   = (key_count_ff == KCW'(MAX_KEY));
   assign cnt_next  = cnt_sat ? key_count_ff : key_count_ff + 1'b1;
   assign i_next    = i_ff + 8'd1;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      sched_in     = sched_ff;
      key_count_in = key_count_ff;
      klen_in      = klen_ff;
      kidx_in      = kidx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      t_in         = t_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      perm_we      = 1'b0;
      perm_wa      = k_ff;
      perm_wd      = k_ff;
      perm_ra      = k_ff;
      key_we       = 1'b0;
      key_wa       = key_count_ff[KEY_AW-1:0];
      key_ra       = kidx_ff;
      j_next       = j_ff + perm_rd;
      t_next       = a_ff + perm_rd;
      ks           = perm_rd;

      unique case (state_ff)
         ST_FILL: begin
            perm_we = 1'b1;
            k_in    = k_ff + 8'd1;
            if (k_ff == 8'hff) begin
               state_in = sched_ff ? ST_M0 : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.op == OP_DATA) begin
                  i_in     = i_next;
                  perm_ra  = i_next;
                  byte_in  = req_data.byte_in;
                  last_in  = req_data.last;
                  state_in = ST_D1;
               end else begin
                  key_we = !cnt_sat;
                  if (req_data.last) begin
                     klen_in      = cnt_next;
                     key_count_in = '0;
                     kidx_in      = '0;
                     k_in         = 8'd0;
                     j_in         = 8'd0;
                     sched_in     = 1'b1;
                     state_in     = ST_FILL;
                  end else begin
                     key_count_in = cnt_next;
                  end
               end
            end
         end
         ST_D1: begin
            a_in     = perm_rd;
            j_in     = j_next;
            perm_ra  = j_next;
            state_in = ST_D2;
         end
         ST_D2: begin
            c_in     = perm_rd;
            perm_we  = 1'b1;
            perm_wa  = i_ff;
            perm_wd  = perm_rd;
            t_in     = t_next;
            perm_ra  = t_next;
            state_in = ST_D3;
         end
         ST_D3: begin
            // The read of perm[t] was taken before either swap write landed.
            priority if (t_ff == j_ff) begin
               ks = a_ff;
            end else if (t_ff == i_ff) begin
               ks = c_ff;
            end else begin
               ks = perm_rd;
            end
            perm_we = 1'b1;
            perm_wa = j_ff;
            perm_wd = a_ff;
            perm_ra = t_ff;
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.byte_out = byte_ff ^ ks;
               rsp_in.last_out = last_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_M0: begin
            state_in = ST_M1;
         end
         ST_M1: begin
            a_in     = perm_rd;
            j_in     = j_next + key_rd;
            perm_ra  = j_next + key_rd;
            state_in = ST_M2;
         end
         ST_M2: begin
            perm_we  = 1'b1;
            perm_wd  = perm_rd;
            state_in = ST_M3;
         end
         ST_M3: begin
            perm_we = 1'b1;
            perm_wa = j_ff;
            perm_wd = a_ff;
            k_in    = k_ff + 8'd1;
            if (KCW'(kidx_ff) + 1'b1 == klen_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + 1'b1;
            end
            if (k_ff == 8'hff) begin
               i_in     = 8'd0;
               j_in     = 8'd0;
               sched_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_M0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         k_ff         <= 8'd0;
         sched_ff     <= 1'b0;
         key_count_ff <= '0;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         sched_ff     <= sched_in;
         key_count_ff <= key_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      klen_ff <= klen_in;
      kidx_ff <= kidx_in;
      a_ff    <= a_in;
      c_ff    <= c_in;
      t_ff    <= t_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/rc4_checker.sv -----
`include "rc4_stream_cipher_top_defines.svh"

module rc4_prop_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input rc4_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rc4_pkg::rsp_type rsp_data
);

   import rc4_pkg::*;

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   `RC4_ASSERT_ALWAYS(a_reset_empties_output, clock, reset |=> !rsp_valid, "Result valid right after reset.")
   `RC4_ASSERT(a_rsp_valid_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "Stalled result was dropped.")
   `RC4_ASSERT(a_rsp_data_held, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "Stalled result changed.")
   `RC4_ASSERT(a_data_busy, clock, reset, req_xfer && req_data.op == OP_DATA |=> req_stall, "Data byte transfer did not make the block busy.")
   `RC4_ASSERT(a_data_latency, clock, reset, req_xfer && req_data.op == OP_DATA && !rsp_valid |-> ##4 rsp_valid, "Result of a data byte missing after four cycles.")

endmodule

bind rc4_stream_cipher_top rc4_prop_checker u_rc4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- sim/rc4_checker.sv -----
`timescale 1ns / 100ps

module rc4_checker #(
   parameter int MAX_KEY = rc4_pkg::MAX_KEY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  rc4_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rc4_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import rc4_pkg::*;

   logic [7:0]  sbox [256];
   logic [7:0]  key_mem [MAX_KEY];
   int unsigned key_len;
   logic [7:0]  idx_i;
   logic [7:0]  idx_j;
   rsp_type     cipher_out_q [$];
   int          errors = 0;

   // Each key byte goes to the key store while it has room, and a last key byte runs the
   // key schedule; a data byte steps the generator and yields one ciphertext byte.
   task automatic absorb_request(input req_type r);
      int unsigned klen;
      logic [7:0]  j;
      logic [7:0]  t;
      logic [7:0]  a;
      logic [7:0]  c;
      logic [7:0]  ks_pos;
      rsp_type     res;
      if (r.op == OP_KEY) begin
         if (key_len < MAX_KEY) begin
            key_mem[key_len] = r.byte_in;
            key_len++;
         end
         if (r.last) begin
            klen = (key_len == 0 || key_len > MAX_KEY) ? MAX_KEY : key_len;
            for (int k = 0; k < 256; k++) begin
               sbox[k] = k[7:0];
            end
            j = 8'd0;
            for (int k = 0; k < 256; k++) begin
               t = sbox[k];
               j = j + t + key_mem[k % klen];
               sbox[k] = sbox[j];
               sbox[j] = t;
            end
            idx_i = 8'd0;
            idx_j = 8'd0;
            key_len = 0;
         end
      end else begin
         idx_i = idx_i + 8'd1;
         a = sbox[idx_i];
         idx_j = idx_j + a;
         c = sbox[idx_j];
         sbox[idx_i] = c;
         sbox[idx_j] = a;
         ks_pos = a + c;
         res.byte_out = r.byte_in ^ sbox[ks_pos];
         res.last_out = r.last;
         cipher_out_q.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < 256; k++) begin
            sbox[k] = k[7:0];
         end
         key_len = 0;
         idx_i = 8'd0;
         idx_j = 8'd0;
         cipher_out_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (cipher_out_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, got byte_out %h last_out %b",
                        $time, rsp_data.byte_out, rsp_data.last_out);
            end else begin
               want = cipher_out_q.pop_front();
               if (rsp_data.byte_out !== want.byte_out) begin
                  errors++;
                  $display("%0t: byte_out expected %h, got %h",
                           $time, want.byte_out, rsp_data.byte_out);
               end
               if (rsp_data.last_out !== want.last_out) begin
                  errors++;
                  $display("%0t: last_out expected %b, got %b",
                           $time, want.last_out, rsp_data.last_out);
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= cipher_out_q.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import rc4_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      sent = 0;
   bit      quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rc4_stream_cipher_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rc4_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_item(input logic op, input logic [7:0] b, input logic lst);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, byte_in: b, last: lst};
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_key_run(input int n, input bit close);
      for (int k = 0; k < n; k++) begin
         send_item(OP_KEY, 8'($urandom_range(0, 255)), close && (k == n - 1));
      end
   endtask

   task automatic send_data_run(input int n);
      logic lst;
      for (int k = 0; k < n; k++) begin
         lst = (k == n - 1);
         if ($urandom_range(0, 7) == 0) begin
            lst = !lst;
         end
         send_item(OP_DATA, 8'($urandom_range(0, 255)), lst);
      end
   endtask

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         hold = quiet ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int sel;
      int klen;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Data on the identity permutation, then short keys, one of them split by data.
      send_item(OP_DATA, 8'h00, 1'b0);
      send_item(OP_DATA, 8'hff, 1'b1);
      send_item(OP_KEY, 8'hff, 1'b1);
      send_item(OP_DATA, 8'h00, 1'b0);
      send_item(OP_DATA, 8'hff, 1'b1);
      send_item(OP_KEY, 8'h00, 1'b0);
      send_item(OP_DATA, 8'h5a, 1'b0);
      send_item(OP_KEY, 8'h80, 1'b0);
      send_item(OP_KEY, 8'h01, 1'b1);
      send_item(OP_DATA, 8'h00, 1'b0);
      send_item(OP_DATA, 8'h55, 1'b0);
      send_item(OP_DATA, 8'haa, 1'b1);
      send_item(OP_KEY, 8'h00, 1'b1);
      send_data_run(4);

      // A key that overruns the store, then one that fills it exactly.
      send_key_run(MAX_KEY_DEFAULT + $urandom_range(1, 4), 1'b1);
      send_data_run(8);
      send_key_run(MAX_KEY_DEFAULT, 1'b1);
      send_data_run(8);

      while (sent < 880) begin
         quiet = ($urandom_range(0, 4) == 0);
         sel   = $urandom_range(0, 9);
         klen  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         if (sel <= 5) begin
            send_key_run(klen, 1'b1);
            send_data_run($urandom_range(1, 24));
         end else if (sel == 6) begin
            send_key_run($urandom_range(1, 6), 1'b0);
            send_data_run($urandom_range(1, 4));
            send_key_run(klen, 1'b1);
            send_data_run($urandom_range(1, 16));
         end else if (sel == 7) begin
            send_data_run($urandom_range(1, 24));
         end else if (sel == 8) begin
            repeat ($urandom_range(1, 8)) begin
               send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
         end else begin
            send_key_run($urandom_range(1, 6), 1'b0);
            send_data_run($urandom_range(1, 8));
         end
      end
      send_data_run(4);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("rc4_stream_cipher_top: match");
      end else begin
         $display("rc4_stream_cipher_top: mismatch");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("rc4_stream_cipher_top: mismatch");
      $finish;
   end

endmodule
